>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the leakoff-rate core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/flr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flr_pkg
// Types, constants and helpers of the leakoff-rate core.
// ---------------------------------------------------------------------------
package flr_pkg;

  // Q24.40 constants
  localparam logic [63:0] SMAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q  = 64'h0000_0100_0000_0000;
  localparam logic [63:0] DP_DIV = 64'd10000;
  localparam logic [63:0] DP_MIN = 64'd110;
  localparam logic [63:0] DP_MAX = 64'd1099511628;

  // ceil(2^58 / 10000): exact floor(x / 10000) for x below 2^44 as (x * DP_RECIP) >> 58
  localparam logic [63:0] DP_RECIP = 64'd28823037615172;

  // Register indexes
  localparam logic [2:0] REG_LEAK_EN    = 3'd0;
  localparam logic [2:0] REG_UPD_EN     = 3'd1;
  localparam logic [2:0] REG_PRESS_IND  = 3'd2;
  localparam logic [2:0] REG_LEAK_COEFF = 3'd3;
  localparam logic [2:0] REG_CLOSURE    = 3'd4;
  localparam logic [2:0] REG_REF_DROP   = 3'd5;
  localparam logic [2:0] REG_SPURT      = 3'd6;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_GPREP, OP_DPDIV, OP_UD, OP_SONE, OP_SDIV, OP_SQ1, OP_C, OP_TZERO,
    OP_QDIV, OP_TST, OP_SQ2, OP_M, OP_RES, OP_RZERO, OP_RDIV, OP_S1DIV,
    OP_S2DIV, OP_FIN
  } op_e;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       go;
    op_e        op;
    logic [1:0] pass;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic done;
    logic leak_en;
    logic press_ind;
    logic neg;
    logic tcond;
    logic dt_zero;
    logic out_full;
  } sts_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  // Signed-magnitude add, magnitude saturates at all ones
  function automatic sm_t smadd(logic an, logic [63:0] am, logic bn, logic [63:0] bm);
    sm_t         r;
    logic [64:0] sum;
    sum = {1'b0, am} + {1'b0, bm};
    if (an == bn) begin
      r.mag = sum[64] ? '1 : sum[63:0];
      r.neg = an;
    end else if (am >= bm) begin
      r.mag = am - bm;
      r.neg = an;
    end else begin
      r.mag = bm - am;
      r.neg = bn;
    end
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/core/flr_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flr_div
// Bit-serial restoring divider: quotient of (num << 40) / den, one bit a cycle.
// ---------------------------------------------------------------------------
module flr_div
  import flr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic        ovf_o
);

  logic         busy_q, busy_d, done_q, done_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [103:0] num_q, num_d;
  logic [63:0]  den_q, den_d, rem_q, rem_d, quo_q, quo_d;
  logic         ovf_q, ovf_d;
  logic [64:0]  trial;
  logic         ge;

  // One restoring step, 104 steps per divide
  always_comb begin
    trial = {rem_q, num_q[103]};
    ge    = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'd104;
      num_d  = {num_i, 40'b0};
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      num_d = {num_q[102:0], 1'b0};
      rem_d = ge ? 64'(trial - {1'b0, den_q}) : trial[63:0];
      quo_d = {quo_q[62:0], ge};
      ovf_d = ovf_q | quo_q[63];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q | quo_q[63];

endmodule

>>> rtl/core/flr_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flr_sqrt
// Digit-by-digit square root of a Q24.40 value, one root bit a cycle.
// ---------------------------------------------------------------------------
module flr_sqrt
  import flr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [63:0] root_o
);

  logic         busy_q, busy_d, done_q, done_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [103:0] rad_q, rad_d;
  logic [53:0]  rem_q, rem_d;
  logic [51:0]  root_q, root_d;
  logic [55:0]  shv, trial;
  logic         ge;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    shv    = {rem_q, rad_q[103:102]};
    trial  = {2'b0, root_q, 2'b01};
    ge     = shv >= trial;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd52;
      rad_d  = {rad_i, 40'b0};
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[101:0], 2'b00};
      rem_d  = ge ? 54'(shv - trial) : shv[53:0];
      root_d = {root_q[50:0], ge};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = {12'b0, root_q};

endmodule

>>> rtl/core/flr_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flr_mul
// Q24.40 multiply: 64x64 product from four 32x32 partial products, >> 40.
// ---------------------------------------------------------------------------
module flr_mul
  import flr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o,
  output logic        ovf_o
);

  logic         busy_q, busy_d, done_q, done_d;
  logic [1:0]   k_q, k_d;
  logic [63:0]  a_q, a_d, b_q, b_d;
  logic [127:0] acc_q, acc_d;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;

  // One partial product per cycle into the accumulator
  always_comb begin
    ah     = k_q[1] ? a_q[63:32] : a_q[31:0];
    bh     = k_q[0] ? b_q[63:32] : b_q[31:0];
    pp     = ah * bh;
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      case (k_q)
        2'd0:    acc_d = acc_q + {64'b0, pp};
        2'd3:    acc_d = acc_q + {pp, 64'b0};
        default: acc_d = acc_q + {32'b0, pp, 32'b0};
      endcase
      k_d = k_q + 2'd1;
      if (k_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = {1'b0, acc_q[102:40]};
  assign ovf_o  = |acc_q[127:103];

endmodule

>>> rtl/core/flr_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flr_dp
// Datapath: config registers, penetration store, operand registers and
// the shared divider, square-root and multiply units.
// ---------------------------------------------------------------------------
module flr_dp
  import flr_pkg::*;
#(
  parameter int unsigned ELEMENTS = 1024,
  parameter int unsigned AW       = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         kind_i,
  input  logic [9:0]   element_i,
  input  logic [63:0]  pressure_i,
  input  logic [62:0]  delta_t_i,
  input  cmd_t         cmd_i,
  output sts_t         sts_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [63:0]  leak_rate_o,
  output logic [63:0]  rate_slope_o,
  output logic [63:0]  next_penetration_o,
  output logic         saturated_o
);

  // Configuration
  logic        leak_en_q, upd_en_q, pind_q;
  logic [62:0] lc_q, ref_q, spurt_q;
  logic [63:0] clo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_en_q <= 1'b1;
      upd_en_q  <= 1'b1;
      pind_q    <= 1'b0;
      lc_q      <= '0;
      clo_q     <= '0;
      ref_q     <= ONE_Q[62:0];
      spurt_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEAK_EN:    leak_en_q <= cfg_data_i[0];
        REG_UPD_EN:     upd_en_q  <= cfg_data_i[0];
        REG_PRESS_IND:  pind_q    <= cfg_data_i[0];
        REG_LEAK_COEFF: lc_q      <= cfg_data_i[62:0];
        REG_CLOSURE:    clo_q     <= cfg_data_i;
        REG_REF_DROP:   ref_q     <= cfg_data_i[62:0];
        REG_SPURT:      spurt_q   <= cfg_data_i[62:0];
        default:        ;
      endcase
    end
  end

  // Item and working registers
  logic        kind_q, inside_q;
  logic [AW-1:0] addr_q;
  logic [63:0] p_q, v_q, rd_q;
  logic [62:0] dt_q;
  logic        gn_q, un_q, dn_q;
  logic [63:0] gm_q, um_q, dm_q, dp_q;
  logic [63:0] s_q, c_q, t_q, sq_q, m_q, rate_q, slope_q;
  logic [63:0] res_q [3];
  logic        sat_q;
  op_e         op_q;

  // Element range check and store index
  logic [16:0]   elem_ext;
  logic          in_inside;
  logic [AW-1:0] in_addr;
  assign elem_ext  = 17'(element_i);
  assign in_inside = elem_ext < 17'(ELEMENTS);
  assign in_addr   = in_inside ? elem_ext[AW-1:0] : '0;

  // Penetration store with clearing sweep
  logic [63:0]   mem [ELEMENTS];
  logic [AW-1:0] clr_cnt_q;
  logic          fin, commit;
  assign fin    = cmd_i.go && (cmd_i.op == OP_FIN);
  assign commit = fin && kind_q && upd_en_q && inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[clr_cnt_q] <= '0;
    end else if (commit) begin
      mem[addr_q] <= res_q[0];
    end
    if (cmd_i.load) begin
      rd_q <= mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Pass operand select: nominal, pressure plus step, pressure minus step
  logic        sel_neg;
  logic [63:0] sel_mag;
  always_comb begin
    case (cmd_i.pass)
      2'd1:    begin sel_neg = un_q; sel_mag = um_q; end
      2'd2:    begin sel_neg = dn_q; sel_mag = dm_q; end
      default: begin sel_neg = gn_q; sel_mag = gm_q; end
    endcase
  end

  // Magnitudes and derived operands
  logic        pn, en, bn, dp_big;
  logic [63:0] pm, em, dpc, tsum, tcap, m2, m2c, msum, vdiff, sdiff;
  logic        rate_neg, slope_neg, m2_ovf, msum_ovf;
  sm_t         g_r, u_r, d_r;

  always_comb begin
    pn   = p_q[63];
    pm   = pn ? 64'(-p_q) : p_q;
    // Above 2^44 the pressure step clamps to its maximum anyway
    dp_big = pm[63:44] != '0;
    en   = clo_q[63];
    em   = en ? 64'(-clo_q) : clo_q;
    bn   = !en && (em != '0);
    g_r  = smadd(pn, pm, bn, em);
    if (dp_q < DP_MIN)      dpc = DP_MIN;
    else if (dp_q > DP_MAX) dpc = DP_MAX;
    else                    dpc = dp_q;
    u_r  = smadd(gn_q, gm_q, 1'b0, dpc);
    d_r  = smadd(gn_q, gm_q, 1'b1, dpc);
    tsum = t_q + {1'b0, dt_q};
    tcap = (tsum > SMAX) ? SMAX : tsum;
    m2       = {m_q[62:0], 1'b0};
    m2_ovf   = m2 > SMAX;
    m2c      = m2_ovf ? SMAX : m2;
    msum     = m2c + {1'b0, spurt_q};
    msum_ovf = msum > SMAX;
    rate_neg  = res_q[0] < v_q;
    vdiff     = rate_neg ? (v_q - res_q[0]) : (res_q[0] - v_q);
    slope_neg = res_q[1] < res_q[2];
    sdiff     = slope_neg ? (res_q[2] - res_q[1]) : (res_q[1] - res_q[2]);
  end

  // Unit start and operand mux
  logic        div_start, div_done, div_ovf;
  logic [63:0] div_num, div_den, div_quo;
  logic        sq_start, sq_done;
  logic [63:0] sq_rad, sq_root;
  logic        mul_start, mul_done, mul_ovf;
  logic [63:0] mul_a, mul_b, mul_p;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    sq_rad    = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd_i.op)
      // Pressure step |p| / 10000 by reciprocal multiply
      OP_DPDIV: begin
        mul_start = cmd_i.go;
        mul_a     = dp_big ? '0 : {20'b0, pm[43:0]};
        mul_b     = DP_RECIP;
      end
      OP_SDIV: begin
        div_start = cmd_i.go; div_num = sel_mag;
        div_den   = (ref_q == '0) ? 64'd1 : {1'b0, ref_q};
      end
      OP_QDIV: begin
        div_start = cmd_i.go; div_num = v_q - {1'b0, spurt_q};
        div_den   = {c_q[62:0], 1'b0};
      end
      OP_RDIV: begin
        div_start = cmd_i.go; div_num = vdiff; div_den = {1'b0, dt_q};
      end
      OP_S1DIV: begin
        div_start = cmd_i.go; div_num = sdiff; div_den = {1'b0, dt_q};
      end
      OP_S2DIV: begin
        div_start = cmd_i.go; div_num = s_q; div_den = {dp_q[62:0], 1'b0};
      end
      OP_SQ1: begin sq_start = cmd_i.go; sq_rad = s_q; end
      OP_SQ2: begin sq_start = cmd_i.go; sq_rad = tcap; end
      OP_C:   begin mul_start = cmd_i.go; mul_a = {1'b0, lc_q}; mul_b = sq_q; end
      OP_TST: begin mul_start = cmd_i.go; mul_a = s_q; mul_b = s_q; end
      OP_M:   begin mul_start = cmd_i.go; mul_a = c_q; mul_b = sq_q; end
      default: ;
    endcase
  end

  flr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quo_o(div_quo), .ovf_o(div_ovf)
  );

  flr_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad), .done_o(sq_done),
    .root_o(sq_root)
  );

  flr_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p), .ovf_o(mul_ovf)
  );

  logic [63:0] div_val, mul_val;
  assign div_val = div_ovf ? SMAX : div_quo;
  assign mul_val = mul_ovf ? SMAX : mul_p;

  // Working registers: load, ops written directly at go and unit write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      addr_q   <= in_addr;
      inside_q <= in_inside;
      p_q      <= pressure_i;
      dt_q     <= delta_t_i;
      sat_q    <= (delta_t_i == '0);
      res_q[0] <= '0;
      res_q[1] <= '0;
      res_q[2] <= '0;
      rate_q   <= '0;
      slope_q  <= '0;
    end
    if (cmd_i.go) begin
      op_q <= cmd_i.op;
      case (cmd_i.op)
        OP_GPREP: begin
          v_q  <= inside_q ? rd_q : '0;
          gn_q <= g_r.neg;
          gm_q <= g_r.mag;
        end
        OP_UD: begin
          dp_q <= dpc;
          un_q <= u_r.neg;
          um_q <= u_r.mag;
          dn_q <= d_r.neg;
          dm_q <= d_r.mag;
        end
        OP_SONE:  s_q <= ONE_Q;
        OP_TZERO: t_q <= '0;
        OP_SQ2:   if (tsum > SMAX) sat_q <= 1'b1;
        OP_RES: begin
          res_q[cmd_i.pass] <= msum_ovf ? SMAX : msum;
          if (m2_ovf || msum_ovf) sat_q <= 1'b1;
        end
        OP_RZERO: res_q[cmd_i.pass] <= '0;
        default: ;
      endcase
    end
    if (div_done) begin
      if (div_ovf) sat_q <= 1'b1;
      case (op_q)
        OP_RDIV:  rate_q  <= div_val;
        OP_S2DIV: slope_q <= div_val;
        default:  s_q     <= div_val;
      endcase
    end
    if (sq_done) begin
      sq_q <= sq_root;
    end
    if (mul_done) begin
      if (mul_ovf) sat_q <= 1'b1;
      case (op_q)
        // Product is shifted by 40 already; 18 more gives the quotient
        OP_DPDIV: dp_q <= dp_big ? DP_MAX : {18'b0, mul_p[63:18]};
        OP_C:     c_q  <= mul_val;
        OP_TST:   t_q  <= mul_val;
        default:  m_q  <= mul_val;
      endcase
    end
  end

  // Output word register
  logic        out_valid_q;
  logic [63:0] o_rate_q, o_slope_q, o_pen_q;
  logic        o_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      o_rate_q  <= rate_neg ? 64'(-rate_q) : rate_q;
      o_slope_q <= slope_neg ? 64'(-slope_q) : slope_q;
      o_pen_q   <= res_q[0];
      o_sat_q   <= sat_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign leak_rate_o        = o_rate_q;
  assign rate_slope_o       = o_slope_q;
  assign next_penetration_o = o_pen_q;
  assign saturated_o        = o_sat_q;

  // Status to the controller
  always_comb begin
    sts_o.clr_last  = clr_cnt_q == AW'(ELEMENTS - 1);
    sts_o.done      = div_done | sq_done | mul_done;
    sts_o.leak_en   = leak_en_q;
    sts_o.press_ind = pind_q;
    sts_o.neg       = sel_neg;
    sts_o.tcond     = (v_q > {1'b0, spurt_q}) && (c_q != '0);
    sts_o.dt_zero   = dt_q == '0;
    sts_o.out_full  = out_valid_q;
  end

endmodule

>>> rtl/core/flr_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flr_ctrl
// Sequencer: clearing sweep, item load, three next-penetration passes,
// rate and slope divides, output push.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module flr_ctrl
  import flr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_READ = 5'd2;
  localparam logic [4:0] S_DP   = 5'd3;
  localparam logic [4:0] S_UD   = 5'd4;
  localparam logic [4:0] S_NP   = 5'd5;
  localparam logic [4:0] S_SDIV = 5'd6;
  localparam logic [4:0] S_SQ1  = 5'd7;
  localparam logic [4:0] S_C    = 5'd8;
  localparam logic [4:0] S_TC   = 5'd9;
  localparam logic [4:0] S_QDIV = 5'd10;
  localparam logic [4:0] S_TST  = 5'd11;
  localparam logic [4:0] S_SQ2  = 5'd12;
  localparam logic [4:0] S_M    = 5'd13;
  localparam logic [4:0] S_RES  = 5'd14;
  localparam logic [4:0] S_NXT  = 5'd15;
  localparam logic [4:0] S_RDIV = 5'd16;
  localparam logic [4:0] S_S1   = 5'd17;
  localparam logic [4:0] S_S2   = 5'd18;
  localparam logic [4:0] S_FIN  = 5'd19;

  logic [4:0] state_q, state_d, unit_next;
  logic [1:0] pass_q, pass_d;
  logic       wait_q, wait_d, unit_st;
  op_e        unit_op;

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    wait_d     = wait_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.pass = pass_q;
    unit_st    = 1'b0;
    unit_op    = OP_DPDIV;
    unit_next  = state_q;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.go = 1'b1;
        cmd_o.op = OP_GPREP;
        pass_d   = '0;
        state_d  = sts_i.leak_en ? S_DP : S_FIN;
      end
      S_DP:   begin unit_st = 1'b1; unit_op = OP_DPDIV; unit_next = S_UD; end
      S_UD: begin
        cmd_o.go = 1'b1;
        cmd_o.op = OP_UD;
        state_d  = S_NP;
      end
      // Per-pass entry: scale of one, below closure, or scale divide
      S_NP: begin
        if (sts_i.press_ind) begin
          cmd_o.go = 1'b1;
          cmd_o.op = OP_SONE;
          state_d  = S_SQ1;
        end else if (sts_i.neg) begin
          cmd_o.go = 1'b1;
          cmd_o.op = OP_RZERO;
          state_d  = S_NXT;
        end else begin
          state_d = S_SDIV;
        end
      end
      S_SDIV: begin unit_st = 1'b1; unit_op = OP_SDIV; unit_next = S_SQ1; end
      S_SQ1:  begin unit_st = 1'b1; unit_op = OP_SQ1;  unit_next = S_C;   end
      S_C:    begin unit_st = 1'b1; unit_op = OP_C;    unit_next = S_TC;  end
      // Fictitious time only when stored penetration exceeds spurt loss and c is nonzero
      S_TC: begin
        if (sts_i.tcond) begin
          state_d = S_QDIV;
        end else begin
          cmd_o.go = 1'b1;
          cmd_o.op = OP_TZERO;
          state_d  = S_SQ2;
        end
      end
      S_QDIV: begin unit_st = 1'b1; unit_op = OP_QDIV; unit_next = S_TST; end
      S_TST:  begin unit_st = 1'b1; unit_op = OP_TST;  unit_next = S_SQ2; end
      S_SQ2:  begin unit_st = 1'b1; unit_op = OP_SQ2;  unit_next = S_M;   end
      S_M:    begin unit_st = 1'b1; unit_op = OP_M;    unit_next = S_RES; end
      S_RES: begin
        cmd_o.go = 1'b1;
        cmd_o.op = OP_RES;
        state_d  = S_NXT;
      end
      S_NXT: begin
        if (pass_q == 2'd2) begin
          state_d = sts_i.dt_zero ? S_FIN : S_RDIV;
        end else begin
          pass_d  = pass_q + 2'd1;
          state_d = S_NP;
        end
      end
      S_RDIV: begin unit_st = 1'b1; unit_op = OP_RDIV;  unit_next = S_S1;  end
      S_S1:   begin unit_st = 1'b1; unit_op = OP_S1DIV; unit_next = S_S2;  end
      S_S2:   begin unit_st = 1'b1; unit_op = OP_S2DIV; unit_next = S_FIN; end
      S_FIN: begin
        if (!sts_i.out_full) begin
          cmd_o.go = 1'b1;
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Unit states: start once, then wait for done
    if (unit_st) begin
      cmd_o.op = unit_op;
      cmd_o.go = !wait_q;
      wait_d   = 1'b1;
      if (sts_i.done) begin
        wait_d  = 1'b0;
        state_d = unit_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      pass_q  <= '0;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      wait_q  <= wait_d;
    end
  end

  `ASSERT_NEXT(a_load_to_read, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_READ, "accepted word did not move to read")
  `ASSERT_IMPL(a_push_free, clk_i, rst_ni, cmd_o.go && (cmd_o.op == OP_FIN), !sts_i.out_full, "output pushed while full")
  `ASSERT_IMPL(a_done_waiting, clk_i, rst_ni, sts_i.done, wait_q, "unit done without a pending start")
  `ASSERT_IMPL(a_pass_range, clk_i, rst_ni, 1'b1, pass_q != 2'd3, "pass counter out of range")

endmodule

>>> rtl/core/fracture_leakoff_rate.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fracture_leakoff_rate
// Carter leakoff rate and pressure slope per fracture element, Q24.40.
// ---------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: element, pressure, delta_t
//                                        tuser: kind
//  m_axis    out  tvalid/tready          tdata: leak_rate, rate_slope,
//                                               next_penetration
//                                        tuser: saturated
//  cfg       in   cfg_we_i (no stall)    cfg_idx_i, cfg_data_i
//
//  After reset the store is swept to zero before the first word is
//  taken; configuration writes are taken during the sweep.
//  One word at a time: with leakoff on, a word takes up to nine 104-step
//  divides on the shared bit-serial divider plus up to six 52-step
//  square roots.
//  A new word is accepted while the previous result waits on m_axis.
// ---------------------------------------------------------------------------
module fracture_leakoff_rate
  import flr_pkg::*;
#(
  parameter int unsigned ELEMENTS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,   // element[9:0], pressure[73:10], delta_t[136:74]
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // leak_rate[63:0], rate_slope[127:64],
                                       // next_penetration[191:128]
  output logic         m_axis_tuser,   // saturated
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  cmd_t        cmd;
  sts_t        sts;
  logic [63:0] leak_rate, rate_slope, next_pen;

  flr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  flr_dp #(
    .ELEMENTS (ELEMENTS),
    .AW       (AW)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .kind_i             (s_axis_tuser),
    .element_i          (s_axis_tdata[9:0]),
    .pressure_i         (s_axis_tdata[73:10]),
    .delta_t_i          (s_axis_tdata[136:74]),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .leak_rate_o        (leak_rate),
    .rate_slope_o       (rate_slope),
    .next_penetration_o (next_pen),
    .saturated_o        (m_axis_tuser)
  );

  assign m_axis_tdata = {next_pen, rate_slope, leak_rate};

endmodule
